// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the deque block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/deq_pkg.sv -----
// Package of the double-ended queue: field widths, command and status codes,
// default sizes and the control struct that drives a row of storage cells.
// Depends on nothing.
package deq_pkg;

	// Default sizes.
	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// Fixed widths of the channel fields.
	localparam int CMD_W   = 3;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Per-cycle control of one row of cells.
	typedef struct packed {
		logic insert_head; // every cell takes its lower neighbor, cell 0 the new word
		logic remove_head; // every cell takes its upper neighbor
		logic write_tail;  // the cell whose index equals the count takes the new word
	} deq_ctrl_t;

endpackage

// ----- sv/deq_if.sv -----
// Handshake interfaces of the double-ended queue: command and response beats.
// Depends on deq_pkg for the field widths.
interface deq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [deq_pkg::CMD_W-1:0]    command;
	logic [deq_pkg::WORD_W-1:0]   value;

	modport source (output valid, command, value, input ready);
	modport sink   (input valid, command, value, output ready);
endinterface

interface deq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [deq_pkg::STAT_W-1:0]    status;
	logic [deq_pkg::WORD_W-1:0]    popped_value;
	logic [deq_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, status, popped_value, entry_count, input ready);
	modport sink   (input valid, status, popped_value, entry_count, output ready);
endinterface

// ----- sv/deq_cell.sv -----
// One storage cell of a row: holds one word and takes a neighbor's word or
// the broadcast word as the control says. Depends on deq_pkg.
module deq_cell #(
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  deq_pkg::deq_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] lower_data,
	input  logic [DATA_WIDTH-1:0] upper_data,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_tail;

	// This cell is the first free slot behind the last word.
	assign is_tail = (count == CNT_W'(INDEX));

	// The word moves with the row; no reset, a slot is read only after a write.
	always_ff @(posedge clk) begin
		if (ctrl.insert_head) begin
			data_q <= lower_data;
		end else if (ctrl.remove_head) begin
			data_q <= upper_data;
		end else if (ctrl.write_tail && is_tail) begin
			data_q <= value;
		end
	end

	assign data = data_q;

endmodule

// ----- sv/deq_row.sv -----
// A row of DEPTH storage cells, head at cell 0, each wired to its neighbors.
// Depends on deq_pkg and deq_cell.
module deq_row #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  deq_pkg::deq_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] value,
	output logic [DATA_WIDTH-1:0] head
);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	// Each cell sees the word below it (the new word at the head) and above it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower_w;
		logic [DATA_WIDTH-1:0] upper_w;

		if (i == 0) begin : g_first
			assign lower_w = value;
		end else begin : g_inner_lo
			assign lower_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign upper_w = cell_data[i];
		end else begin : g_inner_hi
			assign upper_w = cell_data[i+1];
		end

		deq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count),
			.value      (value),
			.lower_data (lower_w),
			.upper_data (upper_w),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ----- sv/double_ended_queue.sv -----
// Top level of the bounded double-ended queue: two rows of cells and a count.
// Depends on deq_pkg, deq_if (deq_cmd_if, deq_rsp_if) and deq_row.
//
//   Port  Dir   Beat carries
//   cmd   sink  command, value
//   rsp   src   status, popped_value, entry_count
//
// One command beat per cycle while no response beat is stalled; its response beat appears in the next cycle.
// The front row keeps the words front-first, the back row keeps the same
// words back-first, so both ends are always at cell 0 of a row.
// Reset clears the count and the response valid flag; payload and cells stay.
// While a response beat waits on rsp.ready, cmd.ready is low.
module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	deq_cmd_if.sink        cmd,
	deq_rsp_if.source      rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_nxt;
	logic                         rsp_valid_q;
	logic [deq_pkg::STAT_W-1:0]   status_q;
	logic [deq_pkg::WORD_W-1:0]   popped_q;
	logic [deq_pkg::COUNT_W-1:0]  entry_q;

	logic                         accept;
	logic                         full;
	logic                         empty;
	logic [DATA_WIDTH-1:0]        word;
	logic [DATA_WIDTH-1:0]        front_head;
	logic [DATA_WIDTH-1:0]        back_head;
	logic [deq_pkg::STAT_W-1:0]   status_nxt;
	logic [deq_pkg::WORD_W-1:0]   popped_nxt;
	deq_pkg::deq_ctrl_t           front_ctrl;
	deq_pkg::deq_ctrl_t           back_ctrl;

	assign accept = cmd.valid && cmd.ready;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign word   = DATA_WIDTH'(cmd.value);

	// Command decode: row controls, next count and the response fields.
	always_comb begin
		front_ctrl = '0;
		back_ctrl  = '0;
		count_nxt  = count_q;
		status_nxt = deq_pkg::ST_OK;
		popped_nxt = '0;
		unique case (cmd.command)
			deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = deq_pkg::ST_FULL;
				end else begin
					front_ctrl.write_tail = accept;
					back_ctrl.insert_head = accept;
					count_nxt             = count_q + CNT_W'(1);
				end
			end
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = deq_pkg::ST_FULL;
				end else begin
					front_ctrl.insert_head = accept;
					back_ctrl.write_tail   = accept;
					count_nxt              = count_q + CNT_W'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = deq_pkg::ST_EMPTY;
				end else begin
					front_ctrl.remove_head = accept;
					popped_nxt             = deq_pkg::WORD_W'(front_head);
					count_nxt              = count_q - CNT_W'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = deq_pkg::ST_EMPTY;
				end else begin
					back_ctrl.remove_head = accept;
					popped_nxt            = deq_pkg::WORD_W'(back_head);
					count_nxt             = count_q - CNT_W'(1);
				end
			end
			deq_pkg::CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	// Front-first row and back-first row of cells.
	deq_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_front_row (
		.clk   (clk),
		.ctrl  (front_ctrl),
		.count (count_q),
		.value (word),
		.head  (front_head)
	);

	deq_row #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_back_row (
		.clk   (clk),
		.ctrl  (back_ctrl),
		.count (count_q),
		.value (word),
		.head  (back_head)
	);

	// Count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, loaded with every accepted command beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			popped_q <= popped_nxt;
			entry_q  <= deq_pkg::COUNT_W'(count_nxt);
		end
	end

	assign cmd.ready        = !rsp_valid_q || rsp.ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.popped_value = popped_q;
	assign rsp.entry_count  = entry_q;

endmodule

// ----- sv/deq_checker.sv -----
// Port-level checker of the double-ended queue and its bind to the top level.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [deq_pkg::STAT_W-1:0]   status,
	input logic [deq_pkg::WORD_W-1:0]   popped_value,
	input logic [deq_pkg::COUNT_W-1:0]  entry_count
);

	localparam logic [deq_pkg::COUNT_W-1:0] FULL_FIELD = deq_pkg::COUNT_W'(DEPTH);

	// A refused push reports a full queue and no word.
	`ASSERT_IMPLY(a_full_count, clk, arst_n, rsp_valid && status == deq_pkg::ST_FULL, entry_count == FULL_FIELD && popped_value == '0, "refused push without full count")

	// A refused pop reports an empty queue and no word.
	`ASSERT_IMPLY(a_empty_count, clk, arst_n, rsp_valid && status == deq_pkg::ST_EMPTY, entry_count == '0 && popped_value == '0, "refused pop with words held")

	// Only the three defined status codes appear.
	`ASSERT_IMPLY(a_status_code, clk, arst_n, rsp_valid, status == deq_pkg::ST_OK || status == deq_pkg::ST_FULL || status == deq_pkg::ST_EMPTY, "undefined status code")

	// A stalled response beat stays and holds its payload.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(popped_value) && $stable(entry_count), "stalled response changed")

endmodule

bind double_ended_queue deq_checker #(
	.DEPTH (DEPTH)
) u_deq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.popped_value (rsp.popped_value),
	.entry_count  (rsp.entry_count)
);
